@@ rtl/psq_pkg.sv @@
// Shared types and constants for the processor-sharing queue.
`timescale 1ns / 1ps
package psq_pkg;
   localparam int MAX_JOBS   = 16;
   localparam int TAG_BITS   = 16;
   localparam int IDX_BITS   = $clog2(MAX_JOBS);
   localparam int CNT_BITS   = $clog2(MAX_JOBS + 1);
   localparam int WORK_BITS  = 32;
   localparam int TAG_OUT    = 16;
   localparam int ADDR_BITS  = 1;
   localparam logic [31:0] RATE_RESET = 32'h0001_0000;

   typedef enum logic [1:0] {
      CMD_ARRIVE  = 2'd0,
      CMD_ADVANCE = 2'd1,
      CMD_DEPART  = 2'd2,
      CMD_NONE    = 2'd3
   } cmd_type;

   localparam logic [ADDR_BITS-1:0] REG_SERVICE_RATE = '0;

   // divider control: start with a 64-bit dividend and a 32-bit divisor
   typedef struct packed {
      logic        start;
      logic [63:0] dividend;
      logic [31:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [63:0] quotient;
   } div_rsp_type;
endpackage

@@ rtl/psq_divider.sv @@
// Radix-2 restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module psq_divider (
   input  logic                clock,
   input  logic                reset,
   input  psq_pkg::div_req_type req,
   output psq_pkg::div_rsp_type rsp
);
   import psq_pkg::*;

   logic [63:0] quo_ff, quo_in;
   logic [32:0] rem_ff, rem_in;
   logic [31:0] dsr_ff, dsr_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [32:0] trial;
   logic [33:0] diff;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff[31:0], quo_ff[63]};
      diff    = {1'b0, trial} - {2'b00, dsr_ff};
      if (req.start) begin
         quo_in  = req.dividend;
         rem_in  = '0;
         dsr_in  = req.divisor;
         cnt_in  = 7'd64;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // shift in one dividend bit, subtract where it fits
         if (!diff[33]) begin
            rem_in = diff[32:0];
            quo_in = {quo_ff[62:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;
endmodule

@@ rtl/processor_sharing_queue.sv @@
// Top level of the processor-sharing queue: job table, sequencer and CSR.
//  channel  | ports         | direction
//  request  | req_*         | in, valid/stall
//  response | rsp_*         | out, valid/stall
//  config   | csr_* (APB)   | in, write/read
// Table sweeps step through the held jobs one entry at a time, and each division runs in the
// shared one-bit-per-cycle divider. Advance on a held queue runs two divisions (share,
// completion time), arrival and depart run one; an empty queue or a zero rate skips the
// completion division.
// Reset is synchronous; it empties the table and sets service_rate to 1.0.
// A stalled response holds; the request side stalls until that response leaves.
`timescale 1ns / 1ps
module processor_sharing_queue (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [1:0]                         req_cmd,
   input  logic [15:0]                        req_job_tag,
   input  logic [31:0]                        req_work_amount,
   input  logic [31:0]                        req_elapsed_time,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [31:0]                        rsp_next_completion,
   output logic                               rsp_queue_empty,
   output logic [4:0]                         rsp_active_count,
   output logic                               rsp_departed_valid,
   output logic [15:0]                        rsp_departed_tag,
   output logic                               rsp_arrival_dropped,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [psq_pkg::ADDR_BITS+1:0]      csr_paddr,
   input  logic [31:0]                        csr_pwdata,
   output logic [31:0]                        csr_prdata,
   output logic                               csr_pready
);
   import psq_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_SHARE_DIV, S_SHARE_WAIT, S_SUB, S_MIN, S_SHIFT,
      S_MIN2, S_MUL, S_CT_WAIT, S_OUT
   } state_type;

   logic [WORK_BITS-1:0] work_mem [MAX_JOBS];
   logic [TAG_BITS-1:0]  tag_mem  [MAX_JOBS];

   state_type            state_ff;
   logic [CNT_BITS-1:0]  count_ff;
   logic [31:0]          rate_ff;
   logic [CNT_BITS-1:0]  ptr_ff;
   logic [IDX_BITS-1:0]  best_ff;
   logic [WORK_BITS-1:0] min_ff;
   logic [31:0]          amount_ff;
   logic                 subbig_ff;
   logic [63:0]          num_ff;
   logic                 dvalid_ff;
   logic [15:0]          dtag_ff;
   logic                 drop_ff;
   logic                 rvalid_ff;
   logic [31:0]          nc_ff;
   div_req_type          dreq;
   div_rsp_type          drsp;
   logic [IDX_BITS-1:0]  pidx;
   logic [IDX_BITS-1:0]  pnext;
   logic                 cfg_wr;
   logic [36:0]          ct_prod;

   psq_divider u_div (.clock(clock), .reset(reset), .req(dreq), .rsp(drsp));

   assign pidx      = ptr_ff[IDX_BITS-1:0];
   assign pnext     = IDX_BITS'(ptr_ff + 1'b1);
   assign ct_prod   = 37'(min_ff) * 37'(count_ff);
   assign cfg_wr    = csr_psel && csr_penable && csr_pwrite &&
                      (csr_paddr[ADDR_BITS+1:2] == REG_SERVICE_RATE);
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[ADDR_BITS+1:2] == REG_SERVICE_RATE) ? rate_ff : '0;
   assign req_stall = (state_ff != S_IDLE) || rvalid_ff;
   assign rsp_valid = rvalid_ff;

   always_comb begin
      dreq          = '0;
      dreq.start    = 1'b0;
      if (state_ff == S_SHARE_DIV) begin
         dreq.start    = 1'b1;
         dreq.dividend = num_ff;
         dreq.divisor  = 32'(count_ff);
      end else if (state_ff == S_MUL && rate_ff != '0) begin
         dreq.start    = 1'b1;
         dreq.dividend = {11'd0, ct_prod, 16'h0000};
         dreq.divisor  = rate_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         count_ff  <= '0;
         rate_ff   <= RATE_RESET;
         rvalid_ff <= 1'b0;
      end else begin
         if (cfg_wr) rate_ff <= csr_pwdata;
         if (rvalid_ff && !rsp_stall) rvalid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid && !req_stall) begin
                  dvalid_ff  <= 1'b0;
                  dtag_ff    <= '0;
                  drop_ff    <= 1'b0;
                  ptr_ff     <= CNT_BITS'(1);
                  best_ff    <= '0;
                  unique case (cmd_type'(req_cmd))
                     CMD_ARRIVE: begin
                        if (count_ff >= CNT_BITS'(MAX_JOBS)) drop_ff <= 1'b1;
                        else begin
                           work_mem[count_ff[IDX_BITS-1:0]] <= req_work_amount;
                           tag_mem[count_ff[IDX_BITS-1:0]]  <=
                              TAG_BITS'(req_job_tag);
                           count_ff <= count_ff + 1'b1;
                        end
                        state_ff <= S_MIN2;
                     end
                     CMD_ADVANCE: begin
                        num_ff   <= 64'(req_elapsed_time) * 64'(rate_ff);
                        state_ff <= (count_ff == '0) ? S_MIN2 : S_SHARE_DIV;
                     end
                     CMD_DEPART: state_ff <= (count_ff == '0) ? S_MIN2 : S_MIN;
                     default:    state_ff <= S_MIN2;
                  endcase
               end
            end
            S_SHARE_DIV: state_ff <= S_SHARE_WAIT;
            S_SHARE_WAIT: if (drsp.done) begin
               amount_ff <= drsp.quotient[47:16];
               subbig_ff <= drsp.quotient[63:48] != '0;
               ptr_ff    <= '0;
               state_ff  <= S_SUB;
            end
            S_SUB: begin
               // saturating subtract, one entry per cycle
               if (ptr_ff < count_ff)
                  work_mem[pidx] <= (subbig_ff || work_mem[pidx] <= amount_ff) ?
                                    '0 : work_mem[pidx] - amount_ff;
               if (ptr_ff >= count_ff || ptr_ff == CNT_BITS'(MAX_JOBS - 1)) begin
                  ptr_ff   <= CNT_BITS'(1);
                  best_ff  <= '0;
                  state_ff <= S_MIN2;
               end else ptr_ff <= ptr_ff + 1'b1;
            end
            S_MIN: begin
               // scan for least work, earliest wins ties
               if (ptr_ff < count_ff && work_mem[pidx] < work_mem[best_ff])
                  best_ff <= pidx;
               if (ptr_ff >= count_ff) begin
                  dvalid_ff <= 1'b1;
                  dtag_ff   <= 16'(tag_mem[best_ff]);
                  amount_ff <= work_mem[best_ff];
                  subbig_ff <= 1'b0;
                  ptr_ff    <= CNT_BITS'(best_ff);
                  state_ff  <= S_SHIFT;
               end else ptr_ff <= ptr_ff + 1'b1;
            end
            S_SHIFT: begin
               // compact the table over the removed entry
               if (ptr_ff + 1'b1 < count_ff) begin
                  work_mem[pidx] <= work_mem[pnext];
                  tag_mem[pidx]  <= tag_mem[pnext];
                  ptr_ff <= ptr_ff + 1'b1;
               end else begin
                  count_ff <= count_ff - 1'b1;
                  ptr_ff   <= '0;
                  state_ff <= S_SUB;
               end
            end
            S_MIN2: begin
               if (ptr_ff < count_ff && work_mem[pidx] < work_mem[best_ff])
                  best_ff <= pidx;
               if (ptr_ff >= count_ff) begin
                  min_ff   <= work_mem[best_ff];
                  state_ff <= S_MUL;
               end else ptr_ff <= ptr_ff + 1'b1;
            end
            S_MUL: begin
               if (count_ff == '0) begin
                  nc_ff <= '0; state_ff <= S_OUT;
               end else if (rate_ff == '0) begin
                  nc_ff <= '1; state_ff <= S_OUT;
               end else state_ff <= S_CT_WAIT;
            end
            S_CT_WAIT: if (drsp.done) begin
               nc_ff    <= (drsp.quotient[63:32] != '0) ? '1 : drsp.quotient[31:0];
               state_ff <= S_OUT;
            end
            S_OUT: begin
               rvalid_ff <= 1'b1;
               state_ff  <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_next_completion = nc_ff;
   assign rsp_queue_empty     = count_ff == '0;
   assign rsp_active_count    = 5'(count_ff);
   assign rsp_departed_valid  = dvalid_ff;
   assign rsp_departed_tag    = dtag_ff;
   assign rsp_arrival_dropped = drop_ff;
endmodule

@@ rtl/psq_checker.sv @@
// Port-level checks for the processor-sharing queue, bound to the top level.
`timescale 1ns / 1ps
module psq_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_queue_empty,
   input logic [4:0]  rsp_active_count,
   input logic [31:0] rsp_next_completion,
   input logic        rsp_departed_valid,
   input logic [15:0] rsp_departed_tag
);
   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_queue_empty == (rsp_active_count == 5'd0)))
      else $error("empty flag disagrees with count");
   a_empty_nc: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_queue_empty |-> rsp_next_completion == 32'd0)
      else $error("empty queue with nonzero completion time");
   a_tag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_departed_valid |-> rsp_departed_tag == 16'd0)
      else $error("tag without departure");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request taken while response waits");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_next_completion))
      else $error("stalled response changed");
endmodule

bind processor_sharing_queue psq_checker u_psq_checker (.*);

@@ test/testbench.sv @@
// Self-checking testbench for the processor-sharing queue.
`timescale 1ns / 1ps
module testbench;
   import psq_pkg::*;

   localparam int SETTLE = 400;
   localparam int LIMIT  = 20000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_cmd = CMD_NONE;
   logic [15:0] req_job_tag = '0;
   logic [31:0] req_work_amount = '0;
   logic [31:0] req_elapsed_time = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_next_completion;
   logic        rsp_queue_empty;
   logic [4:0]  rsp_active_count;
   logic        rsp_departed_valid;
   logic [15:0] rsp_departed_tag;
   logic        rsp_arrival_dropped;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [ADDR_BITS+1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   processor_sharing_queue u_top (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   typedef struct packed {
      logic [31:0] next_completion;
      logic        queue_empty;
      logic [4:0]  active_count;
      logic        departed_valid;
      logic [15:0] departed_tag;
      logic        arrival_dropped;
   } status_type;

   int errors = 0;

   task automatic report(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      $display("MISMATCH %s: got %h, want %h at %0t", what, got, want, $realtime);
   endtask

   class queue_scoreboard;
      logic [31:0] rate = RATE_RESET;
      logic [31:0] work[MAX_JOBS];
      logic [15:0] tags[MAX_JOBS];
      int          count = 0;
      status_type  pending[$];
      int          departures = 0, drops = 0, checked = 0;

      function int least_index();
         int best = 0;
         for (int i = 1; i < count; i++)
            if (work[i] < work[best]) best = i;
         return best;
      endfunction

      function void take_all(logic [63:0] amount);
         for (int i = 0; i < count; i++)
            work[i] = (64'(work[i]) <= amount) ? 32'd0 : work[i] - amount[31:0];
      endfunction

      function void note_request(logic [1:0] cmd, logic [15:0] tag, logic [31:0] w,
                                 logic [31:0] el);
         status_type s;
         logic [63:0] num;
         int k;
         s = '0;
         case (cmd)
            CMD_ARRIVE: begin
               if (count >= MAX_JOBS) s.arrival_dropped = 1'b1;
               else begin
                  work[count] = w;
                  tags[count] = tag;
                  count++;
               end
            end
            CMD_ADVANCE: begin
               if (count > 0) take_all(((64'(el) * 64'(rate)) / 64'(count)) >> 16);
            end
            CMD_DEPART: begin
               if (count > 0) begin
                  logic [31:0] wmin;
                  k = least_index();
                  wmin = work[k];
                  s.departed_valid = 1'b1;
                  s.departed_tag = tags[k];
                  for (int i = k; i + 1 < count; i++) begin
                     work[i] = work[i+1];
                     tags[i] = tags[i+1];
                  end
                  count--;
                  take_all(64'(wmin));
               end
            end
            default: ;
         endcase
         if (count > 0) begin
            num = (64'(work[least_index()]) * 64'(count)) << 16;
            if (rate == 0) s.next_completion = '1;
            else if (num / 64'(rate) > 64'hFFFF_FFFF) s.next_completion = '1;
            else s.next_completion = 32'(num / 64'(rate));
         end
         s.queue_empty = (count == 0);
         s.active_count = 5'(count);
         if (s.departed_valid) departures++;
         if (s.arrival_dropped) drops++;
         pending.push_back(s);
      endfunction

      task check_response(status_type got);
         status_type want;
         checked++;
         if (pending.size() == 0) begin
            report("unexpected transaction", 32'd0, 32'd0);
            return;
         end
         want = pending.pop_front();
         if (got.next_completion !== want.next_completion)
            report("next_completion", got.next_completion, want.next_completion);
         if (got.queue_empty !== want.queue_empty)
            report("queue_empty", 32'(got.queue_empty), 32'(want.queue_empty));
         if (got.active_count !== want.active_count)
            report("active_count", 32'(got.active_count), 32'(want.active_count));
         if (got.departed_valid !== want.departed_valid)
            report("departed_valid", 32'(got.departed_valid), 32'(want.departed_valid));
         if (got.departed_tag !== want.departed_tag)
            report("departed_tag", 32'(got.departed_tag), 32'(want.departed_tag));
         if (got.arrival_dropped !== want.arrival_dropped)
            report("arrival_dropped", 32'(got.arrival_dropped), 32'(want.arrival_dropped));
      endtask
   endclass

   queue_scoreboard board = new();
   int idle_cycles = 0;
   int rsp_wait = 0;

   // response side: draw a stall length per transaction, check on accept
   always @(posedge clock) begin : rsp_side
      int draw;
      draw = $urandom_range(0, 5);
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_wait  <= 0;
      end else if (rsp_valid && !rsp_stall) begin
         board.check_response({rsp_next_completion, rsp_queue_empty, rsp_active_count,
                               rsp_departed_valid, rsp_departed_tag, rsp_arrival_dropped});
         rsp_wait  <= draw;
         rsp_stall <= (draw != 0);
      end else if (rsp_valid && rsp_stall) begin
         rsp_wait <= rsp_wait - 1;
         if (rsp_wait <= 1) rsp_stall <= 1'b0;
      end
   end

   // watchdog: cycles without any accepted transaction
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset)
         idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= LIMIT) begin
         $display("Watchdog expired");
         $display("Verification failed");
         $finish;
      end
   end

   task automatic send(logic [1:0] cmd, logic [15:0] tag, logic [31:0] w, logic [31:0] el);
      int gap;
      gap = $urandom_range(0, 5);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_job_tag <= tag;
      req_work_amount <= w;
      req_elapsed_time <= el;
      do @(posedge clock); while (req_stall);
      board.note_request(cmd, tag, w, el);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_rate(logic [31:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= {REG_SERVICE_RATE, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      board.rate = value;
   endtask

   function automatic logic [31:0] rand_work();
      case ($urandom_range(0, 5))
         0: return 32'd0;
         1: return 32'hFFFF_FFFF;
         2: return $urandom_range(0, 255);
         3: return $urandom_range(0, 32'h0010_0000);
         default: return $urandom();
      endcase
   endfunction

   task automatic random_phase(int items);
      int c;
      for (int n = 0; n < items; n++) begin
         c = $urandom_range(0, 19);
         if (c < 8) send(CMD_ARRIVE, 16'($urandom()), rand_work(), $urandom());
         else if (c < 13) send(CMD_ADVANCE, 16'($urandom()), $urandom(), rand_work());
         else if (c < 19) send(CMD_DEPART, 16'($urandom()), $urandom(), $urandom());
         else send(CMD_NONE, 16'($urandom()), $urandom(), $urandom());
      end
   endtask

   logic [31:0] rates[6] = '{32'h0001_0000, 32'd1, 32'hFFFF_FFFF, 32'd0,
                             32'h0000_8000, 32'h0003_0000};

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      // directed: empty-queue cases, ties, full table, extremes
      send(CMD_ADVANCE, 16'h0, 32'h0, 32'hFFFF_FFFF);
      send(CMD_DEPART, 16'h0, 32'h0, 32'h0);
      send(CMD_NONE, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send(CMD_ARRIVE, 16'hFFFF, 32'h0001_0000, 32'h0);
      send(CMD_ARRIVE, 16'h0000, 32'h0001_0000, 32'h0);
      send(CMD_DEPART, 16'h0, 32'h0, 32'h0);
      for (int i = 0; i < MAX_JOBS + 1; i++)
         send(CMD_ARRIVE, 16'(i * 16'h0F0F), (i == 3) ? 32'hFFFF_FFFF : 32'(i * 32'h0002_0000),
              32'h0);
      send(CMD_ADVANCE, 16'h0, 32'h0, 32'hFFFF_FFFF);
      send(CMD_DEPART, 16'h0, 32'h0, 32'h0);
      drain();
      foreach (rates[r]) begin
         write_rate(rates[r]);
         random_phase(300);
         drain();
      end
      random_phase(30);
      drain();
      $display("Covered %0d responses, %0d departures, %0d dropped arrivals,",
               board.checked, board.departures, board.drops);
      $display("over %0d service rate settings including zero and full scale.", $size(rates));
      if (errors == 0 && board.pending.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end
endmodule

@@ files.f @@
rtl/psq_pkg.sv
rtl/psq_divider.sv
rtl/processor_sharing_queue.sv
rtl/psq_checker.sv
test/testbench.sv
